/* rtl/glu_pkg.sv */
package glu_pkg;

  localparam int unsigned IN_W  = 32;
  localparam int unsigned GCD_W = 32;
  localparam int unsigned LCM_W = 63;

  typedef struct packed {
    logic busy;
    logic done;
  } glu_stat_t;

endpackage

/* rtl/glu_gcd.sv */
module glu_gcd import glu_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output glu_stat_t    stat_o,
  output logic [W-1:0] gcd_o
);

  localparam int unsigned KW = $clog2(W);

  localparam logic [1:0] G_IDLE    = 2'd0;
  localparam logic [1:0] G_TWOS    = 2'd1;
  localparam logic [1:0] G_REDUCE  = 2'd2;
  localparam logic [1:0] G_RESTORE = 2'd3;

  logic [1:0]    st_q, st_d;
  logic          done_q, done_d;
  logic [KW-1:0] k_q, k_d;
  logic [W-1:0]  x_q, x_d, y_q, y_d;
  logic [W:0]    diff;

  // shared subtract: y - x, borrow tells which is larger
  assign diff = {1'b0, y_q} - {1'b0, x_q};

  always_comb begin
    st_d   = st_q;
    k_d    = k_q;
    x_d    = x_q;
    y_d    = y_q;
    done_d = 1'b0;
    unique case (st_q)
      G_IDLE: begin
        if (start_i) begin
          x_d  = a_i;
          y_d  = b_i;
          k_d  = '0;
          st_d = G_TWOS;
        end
      end
      G_TWOS: begin
        if (x_q == '0 || y_q == '0) begin
          x_d  = x_q | y_q;
          st_d = G_RESTORE;
        end else if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + KW'(1);
        end else begin
          st_d = G_REDUCE;
        end
      end
      G_REDUCE: begin
        if (y_q == '0) begin
          st_d = G_RESTORE;
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (!diff[W]) begin
          y_d = diff[W-1:0];
        end else begin
          x_d = W'(~diff + 1'b1);
        end
      end
      G_RESTORE: begin
        if (k_q == '0) begin
          done_d = 1'b1;
          st_d   = G_IDLE;
        end else begin
          x_d = x_q << 1;
          k_d = k_q - KW'(1);
        end
      end
      default: st_d = G_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= G_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    x_q <= x_d;
    y_q <= y_d;
  end

  assign stat_o.busy = (st_q != G_IDLE);
  assign stat_o.done = done_q;
  assign gcd_o       = x_q;

endmodule

/* rtl/glu_div.sv */
module glu_div import glu_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output glu_stat_t    stat_o,
  output logic [W-1:0] quot_o
);

  localparam int unsigned CW = $clog2(W);

  logic          busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [W:0]    trial;
  logic [W+1:0]  diff;

  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (busy_q) begin
      rem_d = diff[W+1] ? trial[W-1:0] : diff[W-1:0];
      quo_d = {quo_q[W-2:0], ~diff[W+1]};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

/* rtl/glu_mul.sv */
module glu_mul import glu_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   mplier_i,
  input  logic [W-1:0]   mcand_i,
  output glu_stat_t      stat_o,
  output logic [2*W-1:0] prod_o
);

  localparam int unsigned CW = $clog2(W);

  logic          busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W:0]    hi_q, hi_d, sum;
  logic [W-1:0]  lo_q, lo_d, mcand_q, mcand_d;

  assign sum = hi_q + (lo_q[0] ? {1'b0, mcand_q} : '0);

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    mcand_d = mcand_q;
    if (busy_q) begin
      hi_d  = {1'b0, sum[W:1]};
      lo_d  = {sum[0], lo_q[W-1:1]};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = CW'(W - 1);
      hi_d    = '0;
      lo_d    = mplier_i;
      mcand_d = mcand_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    mcand_q <= mcand_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = {hi_q[W-1:0], lo_q};

endmodule

/* rtl/gcd_lcm_unit.sv */
// Channel | Handshake                  | Payload
// in      | in_valid_i / in_stall_o    | first_operand_i, second_operand_i
// out     | out_valid_o / out_stall_i  | gcd_value_o, lcm_value_o
//
// One item at a time: binary gcd (common-twos, subtract/shift, restore),
// then W-step restoring division |a|/gcd, then W-step shift-add multiply by |b|.
// (W = OPERAND_WIDTH); the gcd loop makes the total time depend on the operands.
// in_stall_o is high from acceptance until the result enters the output register.
// A result waiting on out_stall_i does not block acceptance of the next item.
// rst_ni clears the sequencer and output valid; no clearing pass.
module gcd_lcm_unit import glu_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [IN_W-1:0]  first_operand_i,
  input  logic [IN_W-1:0]  second_operand_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [GCD_W-1:0] gcd_value_o,
  output logic [LCM_W-1:0] lcm_value_o
);

  localparam int unsigned W = OPERAND_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]       st_q, st_d;
  logic             out_valid_q, out_valid_d;
  logic [W-1:0]     a_q, b_q, g_q;
  logic [W-1:0]     fa, fb, mag_a, mag_b, gcd_res, quot;
  logic [2*W-1:0]   prod;
  logic [GCD_W-1:0] gcd_out_q;
  logic [LCM_W-1:0] lcm_out_q;
  logic             in_xfer, load_out;
  glu_stat_t        gcd_stat, div_stat, mul_stat;

  assign fa    = first_operand_i[W-1:0];
  assign fb    = second_operand_i[W-1:0];
  assign mag_a = fa[W-1] ? W'(~fa + 1'b1) : fa;
  assign mag_b = fb[W-1] ? W'(~fb + 1'b1) : fb;

  assign in_stall_o = (st_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign load_out   = (st_q == S_OUT) && (!out_valid_q || !out_stall_i);

  glu_gcd #(.W(W)) u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .a_i     (mag_a),
    .b_i     (mag_b),
    .stat_o  (gcd_stat),
    .gcd_o   (gcd_res)
  );

  glu_div #(.W(W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (gcd_stat.done),
    .dividend_i (a_q),
    .divisor_i  (gcd_res),
    .stat_o     (div_stat),
    .quot_o     (quot)
  );

  glu_mul #(.W(W)) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_stat.done),
    .mplier_i (quot),
    .mcand_i  (b_q),
    .stat_o   (mul_stat),
    .prod_o   (prod)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE:  if (in_xfer) st_d = S_GCD;
      S_GCD:   if (gcd_stat.done) st_d = S_DIV;
      S_DIV:   if (div_stat.done) st_d = S_MUL;
      S_MUL:   if (mul_stat.done) st_d = S_OUT;
      S_OUT:   if (load_out) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_q <= mag_a;
      b_q <= mag_b;
    end
    if (gcd_stat.done) begin
      g_q <= gcd_res;
    end
    if (load_out) begin
      gcd_out_q <= GCD_W'(g_q);
      lcm_out_q <= LCM_W'(prod[2*W-2:0]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign gcd_value_o = gcd_out_q;
  assign lcm_value_o = lcm_out_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> st_q == S_GCD)
    else $error("accepted item did not start gcd");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(st_q) == S_OUT)
    else $error("output valid raised outside output step");

  a_gcd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcd_stat.busy |-> st_q == S_GCD)
    else $error("gcd unit busy outside gcd step");

  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> st_q == S_DIV)
    else $error("divider busy outside division step");

  a_mul_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_stat.busy |-> st_q == S_MUL)
    else $error("multiplier busy outside multiply step");

  a_zero_gcd_lcm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gcd_value_o == '0 |-> lcm_value_o == '0)
    else $error("nonzero lcm with zero gcd");

endmodule
